// File: rtl/nmea_sentence_checksum_validator_unit_defines.svh
// assertion macros for the nmea sentence checker
// used by the top level; expects clk and rst in scope
`ifndef NMEA_SENTENCE_CHECKSUM_VALIDATOR_UNIT_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NSCV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NSCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nscv_pkg.sv
// shared types, constants and helpers for the nmea sentence checker
// no dependencies
package nscv_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned HEX_W     = 16;
  localparam int unsigned DIGITS_W  = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CHAR_W-1:0]  CHR_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0]  CHR_STAR   = 8'h2A;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [DIGITS_W-1:0] DIGITS_MAX = 2'd3;

  // register map
  localparam logic [PADDR_W-1:0]  ADDR_MAX_LENGTH  = 3'd0;
  localparam logic [COUNT_W-1:0]  MAX_LENGTH_RESET = 8'd82;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_DOLLAR = 3'd1,
    STAT_TOO_LONG  = 3'd2,
    STAT_MISMATCH  = 3'd3,
    STAT_NO_DIGITS = 3'd4
  } status_t;

  // running sentence state after the current character
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [CHAR_W-1:0]   xsum;
    logic                first_ok;
    logic                seen_star;
    logic [HEX_W-1:0]    hex_value;
    logic [DIGITS_W-1:0] hex_digits;
    logic                hex_done;
  } scan_t;

  // one verdict word
  typedef struct packed {
    logic               ok;
    status_t            status;
    logic [CHAR_W-1:0]  sum;
    logic [COUNT_W-1:0] length;
  } result_t;

  // digit value in [3:0], bit 4 set when not a hex digit
  function automatic logic [4:0] hex_of(input logic [CHAR_W-1:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    return d;
  endfunction

endpackage

// File: rtl/nscv_scan.sv
// per-character sentence state: count, xor, star and hex digit tracking
// depends on nscv_pkg
module nscv_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [nscv_pkg::CHAR_W-1:0] char_byte,
  input  logic                       last_char,
  output nscv_pkg::scan_t            scan_next
);
  import nscv_pkg::*;

  scan_t cur;
  logic [4:0] digit;

  // next state for the character at the input
  always_comb begin
    scan_next = cur;
    digit     = hex_of(char_byte);
    if (cur.count != COUNT_MAX) begin
      scan_next.count = cur.count + 8'd1;
    end
    if (cur.count == '0) begin
      scan_next.first_ok = (char_byte == CHR_DOLLAR);
    end else if (!cur.seen_star) begin
      if (char_byte == CHR_STAR) begin
        scan_next.seen_star = 1'b1;
      end else begin
        scan_next.xsum = cur.xsum ^ char_byte;
      end
    end else if (!cur.hex_done) begin
      if (!digit[4]) begin
        scan_next.hex_value = {cur.hex_value[HEX_W-5:0], digit[3:0]};
        if (cur.hex_digits != DIGITS_MAX) begin
          scan_next.hex_digits = cur.hex_digits + 2'd1;
        end
      end else begin
        scan_next.hex_done = 1'b1;
      end
    end
  end

  // state register, cleared after each sentence
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (take) begin
      if (last_char) begin
        cur <= '0;
      end else begin
        cur <= scan_next;
      end
    end
  end

endmodule

// File: rtl/nscv_judge.sv
// sentence verdict from the final running state
// depends on nscv_pkg
module nscv_judge (
  input  nscv_pkg::scan_t              scan_next,
  input  logic [nscv_pkg::COUNT_W-1:0] max_length,
  output nscv_pkg::result_t            result
);
  import nscv_pkg::*;

  logic [HEX_W-1:0] ext;
  status_t          st;

  // sign-extended sum against the received number, in priority order
  always_comb begin
    ext = {{(HEX_W-CHAR_W){scan_next.xsum[CHAR_W-1]}}, scan_next.xsum};
    priority if (!scan_next.first_ok) begin
      st = STAT_NO_DOLLAR;
    end else if (scan_next.count > max_length) begin
      st = STAT_TOO_LONG;
    end else if (scan_next.seen_star && scan_next.hex_digits == '0) begin
      st = STAT_NO_DIGITS;
    end else if (scan_next.seen_star && ext != scan_next.hex_value) begin
      st = STAT_MISMATCH;
    end else begin
      st = STAT_OK;
    end
    result.ok     = (st == STAT_OK);
    result.status = st;
    result.sum    = scan_next.xsum;
    result.length = scan_next.count;
  end

endmodule

// File: rtl/nscv_outbuf.sv
// output word register with a skid stage behind it
// depends on nscv_pkg
module nscv_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  nscv_pkg::result_t push_word,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output nscv_pkg::result_t out_word
);
  import nscv_pkg::*;

  result_t skid_word;
  logic    skid_valid;

  assign room = !skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (push) begin
        out_word <= push_word;
      end
    end else if (push) begin
      skid_word <= push_word;
    end
  end

endmodule

// File: rtl/nmea_sentence_checksum_validator_unit.sv
// top level of the nmea sentence checker: config register, scan, verdict, output buffer
// depends on nscv_pkg, nscv_scan, nscv_judge, nscv_outbuf and the defines header
//
// usage:
//   input channel (in_valid/in_ready) carries one sentence character per word,
//   with last_char set on the final character. output channel (out_valid/out_ready)
//   carries one verdict word per sentence: sentence_ok, status, computed_sum and
//   sentence_length.
//   max_length is written over the apb port at byte address 0 (reset 82); write
//   it only while no sentence is in flight.
//   throughput: one character per cycle while in_ready is high; the running state is
//   combinational logic between the state registers and the output register.
//   the verdict is registered into the output register, or into the skid stage on a stall.
//   when the receiver stalls, a second verdict is caught in a skid stage and
//   in_ready drops only while that stage is full, so characters that are not
//   final still flow in as long as the skid stage is empty.
//   reset clears the running state, both output stages and sets max_length to 82.
module nmea_sentence_checksum_validator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nscv_pkg::PADDR_W-1:0] paddr,
  input  logic [nscv_pkg::PDATA_W-1:0] pwdata,
  output logic [nscv_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nscv_pkg::CHAR_W-1:0]  char_byte,
  input  logic                        last_char,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        sentence_ok,
  output logic [nscv_pkg::STATUS_W-1:0] status,
  output logic [nscv_pkg::CHAR_W-1:0]  computed_sum,
  output logic [nscv_pkg::COUNT_W-1:0] sentence_length
);
  import nscv_pkg::*;
  `include "nmea_sentence_checksum_validator_unit_defines.svh"

  logic [COUNT_W-1:0] max_length;
  logic               take;
  logic               room;
  scan_t              scan_next;
  result_t            verdict;
  result_t            out_word;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_MAX_LENGTH) begin
      max_length <= pwdata[COUNT_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MAX_LENGTH) begin
      prdata = {{(PDATA_W-COUNT_W){1'b0}}, max_length};
    end
  end

  // input handshake
  assign in_ready = room;
  assign take     = in_valid && in_ready;

  nscv_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_byte (char_byte),
    .last_char (last_char),
    .scan_next (scan_next)
  );

  nscv_judge u_judge (
    .scan_next  (scan_next),
    .max_length (max_length),
    .result     (verdict)
  );

  nscv_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && last_char),
    .push_word (verdict),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // result word out
  assign sentence_ok     = out_word.ok;
  assign status          = out_word.status;
  assign computed_sum    = out_word.sum;
  assign sentence_length = out_word.length;

  // checks
  `NSCV_ASSERT_IMP(a_skid_behind_out, !in_ready, out_valid, "skid full with empty output")
  `NSCV_ASSERT_NEXT(a_final_gives_word, take && last_char, out_valid, "final word lost")
  `NSCV_ASSERT_IMP(a_ok_matches_status, out_valid, sentence_ok == (status == STAT_OK), "ok flag disagrees with status")
  `NSCV_ASSERT_IMP(a_too_long_len, out_valid && status == STAT_TOO_LONG, sentence_length > max_length, "too long verdict on short sentence")

endmodule
